FILE: rtl/acs_pkg.sv
// Shared types, constants and constant-divider helpers for the airband channel stepper.
`default_nettype none

package acs_pkg;

    // Band limits, MHz part
    localparam logic [7:0] MHZ_MIN = 8'd118;
    localparam logic [7:0] MHZ_MAX = 8'd136;

    // kHz part limits and clamps
    localparam logic [9:0] KHZ_TOP_FINE    = 10'd990;
    localparam logic [9:0] KHZ_TOP_25      = 10'd975;
    localparam logic [9:0] KHZ_UP_LIMIT    = 10'd985;
    localparam logic [9:0] KHZ_25_UP_LIMIT = 10'd950;
    localparam logic [9:0] KHZ_PER_MHZ     = 10'd1000;

    // Configuration register indexes
    localparam logic CFG_IDX_R25  = 1'b0;
    localparam logic CFG_IDX_R833 = 1'b1;

    // Request kinds
    localparam logic REQ_MHZ = 1'b0;
    localparam logic REQ_KHZ = 1'b1;

    typedef struct packed {
        logic       r25_en;
        logic       r833_en;
    } t_cfg;

    typedef struct packed {
        logic       s2;
        logic       s3;
        logic       s4;
        logic       s5;
        logic       s6;
    } t_ld;

    typedef struct packed {
        logic       req_type;
        logic       step_up;
        logic       large_step;
        logic [7:0] mhz;
        logic [9:0] khz;
    } t_req;

    typedef struct packed {
        t_req       req;
        logic [5:0] q25;
        logic [4:0] r25;
    } t_split;

    typedef struct packed {
        logic [7:0] mhz;
        logic [9:0] khz;
        logic       changed;
    } t_res;

    typedef struct packed {
        logic [7:0]  mhz;
        logic [9:0]  khz;
        logic        changed;
        logic        freq_valid;
        logic [11:0] packed_code;
    } t_out;

    // k/25 for k < 1024, by reciprocal multiply
    function automatic logic [5:0] div25(input logic [9:0] k);
        logic [15:0] p;
        p = {6'd0, k} * 16'd41;
        return p[15:10];
    endfunction

    // k/10 for k < 1024
    function automatic logic [6:0] div10(input logic [9:0] k);
        logic [17:0] p;
        p = {8'd0, k} * 18'd205;
        return p[17:11];
    endfunction

    // k/100 for k < 1024 (result only used for k < 1000)
    function automatic logic [3:0] div100(input logic [9:0] k);
        logic [15:0] p;
        p = {6'd0, k} * 16'd41;
        return p[15:12];
    endfunction

    // r/5 for r < 25
    function automatic logic [2:0] div5s(input logic [4:0] r);
        logic [9:0] p;
        p = {5'd0, r} * 10'd13;
        return p[8:6];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acs_khz_split.sv
// Stages 2 and 3: splits the kHz part into quotient and remainder of 25.
`default_nettype none

module acs_khz_split (
    input  wire               i_clk,
    input  wire acs_pkg::t_ld i_ld,
    input  acs_pkg::t_req     i_req,
    output acs_pkg::t_split   o_split
);

    acs_pkg::t_req   r_s2_req;
    logic [5:0]      r_s2_q25;
    acs_pkg::t_split r_s3;

    logic [9:0] w_base;
    logic [9:0] w_rem;

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_s2_req <= i_req;
            r_s2_q25 <= acs_pkg::div25(i_req.khz);
        end
    end

    assign w_base = {4'd0, r_s2_q25} * 10'd25;
    assign w_rem  = r_s2_req.khz - w_base;

    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r_s3.req <= r_s2_req;
            r_s3.q25 <= r_s2_q25;
            r_s3.r25 <= w_rem[4:0];
        end
    end

    assign o_split = r_s3;

endmodule

`default_nettype wire

FILE: rtl/acs_step.sv
// Stage 4: applies the MHz or kHz step under the enabled rasters.
`default_nettype none

module acs_step (
    input  wire               i_clk,
    input  wire               i_ld,
    input  acs_pkg::t_cfg     i_cfg,
    input  acs_pkg::t_split   i_split,
    output acs_pkg::t_res     o_res
);

    acs_pkg::t_res r_res;

    logic [9:0] w_k;
    logic [4:0] w_r;
    logic [2:0] w_a;
    logic [2:0] w_b;
    logic [2:0] w_dec;
    logic [2:0] w_inc;
    logic       w_rx20;
    logic       w_rx0;
    logic [9:0] w_base;
    logic [9:0] w_dn_grid;
    logic [9:0] w_up_grid;
    logic [9:0] w_dn_both;
    logic [9:0] w_dn_833;
    logic [9:0] w_up_both;
    logic [9:0] w_up_833;
    logic [9:0] w_dn_lg_833;
    logic [9:0] w_up_lg_833;
    logic [9:0] n_khz;
    logic [7:0] n_mhz;
    logic       n_changed;

    always_comb begin
        w_k    = i_split.req.khz;
        w_r    = i_split.r25;
        w_a    = acs_pkg::div5s(w_r);
        w_b    = 3'(w_r - {w_a, 2'b00} - {2'd0, w_a});
        w_dec  = (w_b == 3'd0) ? 3'd5 : w_b;
        w_inc  = 3'd5 - w_b;
        // remainder mod 25 of the next lower multiple of five lands on 20 or 0
        w_rx20 = ((w_b == 3'd0) && (w_r == 5'd0)) || ((w_b != 3'd0) && (w_a == 3'd4));
        w_rx0  = ((w_b != 3'd0) && (w_a == 3'd0)) || ((w_b == 3'd0) && (w_r == 5'd5));

        w_base    = {4'd0, i_split.q25} * 10'd25;
        w_dn_grid = w_base - ((w_r == 5'd0) ? 10'd25 : 10'd0);
        w_up_grid = w_base + 10'd25;

        w_dn_both = w_k - {7'd0, w_dec} - (w_rx20 ? 10'd5 : 10'd0);
        w_dn_833  = w_k - {7'd0, w_dec}
                    - (w_rx20 ? 10'd5 : (w_rx0 ? 10'd10 : 10'd0));
        w_up_both = w_k + {7'd0, w_inc} + ((w_a == 3'd3) ? 10'd5 : 10'd0);
        w_up_833  = w_k + {7'd0, w_inc}
                    + ((w_a == 3'd3) ? 10'd10 : ((w_a == 3'd4) ? 10'd5 : 10'd0));

        w_dn_lg_833 = (w_r >= 5'd6) ? (w_base + 10'd5) : (w_base - 10'd20);
        w_up_lg_833 = ((w_base + 10'd30) > acs_pkg::KHZ_TOP_FINE) ?
                      acs_pkg::KHZ_TOP_FINE : (w_base + 10'd30);

        n_khz = w_k;
        unique case ({i_cfg.r25_en, i_cfg.r833_en})
            2'b11: begin
                if (!i_split.req.step_up) begin
                    priority if (w_k <= 10'd5)                    n_khz = 10'd0;
                    else if (w_k > acs_pkg::KHZ_TOP_FINE)          n_khz = acs_pkg::KHZ_TOP_FINE;
                    else if (i_split.req.large_step)               n_khz = w_dn_grid;
                    else                                           n_khz = w_dn_both;
                end else begin
                    priority if (w_k >= acs_pkg::KHZ_UP_LIMIT)
                        n_khz = i_split.req.large_step ? acs_pkg::KHZ_TOP_25
                                                       : acs_pkg::KHZ_TOP_FINE;
                    else if (i_split.req.large_step) begin
                        n_khz = (w_k >= acs_pkg::KHZ_25_UP_LIMIT) ? acs_pkg::KHZ_TOP_25
                                                                  : w_up_grid;
                    end else                                       n_khz = w_up_both;
                end
            end
            2'b10: begin
                if (!i_split.req.step_up) begin
                    priority if (w_k <= 10'd25)                   n_khz = 10'd0;
                    else if (w_k > acs_pkg::KHZ_TOP_25)            n_khz = acs_pkg::KHZ_TOP_25;
                    else                                           n_khz = w_dn_grid;
                end else begin
                    n_khz = (w_k >= acs_pkg::KHZ_25_UP_LIMIT) ? acs_pkg::KHZ_TOP_25
                                                              : w_up_grid;
                end
            end
            2'b01: begin
                if (!i_split.req.step_up) begin
                    priority if (w_k <= 10'd10)                   n_khz = 10'd5;
                    else if (w_k > acs_pkg::KHZ_TOP_FINE)          n_khz = acs_pkg::KHZ_TOP_FINE;
                    else if (i_split.req.large_step)               n_khz = w_dn_lg_833;
                    else                                           n_khz = w_dn_833;
                end else begin
                    priority if (w_k < 10'd5)                     n_khz = 10'd5;
                    else if (w_k >= acs_pkg::KHZ_UP_LIMIT)         n_khz = acs_pkg::KHZ_TOP_FINE;
                    else if (i_split.req.large_step)               n_khz = w_up_lg_833;
                    else                                           n_khz = w_up_833;
                end
            end
            default: n_khz = w_k;
        endcase

        n_mhz = i_split.req.mhz;
        if (i_split.req.step_up) begin
            if (i_split.req.mhz < acs_pkg::MHZ_MAX) n_mhz = i_split.req.mhz + 8'd1;
        end else begin
            if (i_split.req.mhz > acs_pkg::MHZ_MIN) n_mhz = i_split.req.mhz - 8'd1;
        end

        if (i_split.req.req_type == acs_pkg::REQ_KHZ) begin
            n_mhz     = i_split.req.mhz;
            n_changed = (n_khz != w_k);
        end else begin
            n_khz     = w_k;
            n_changed = (n_mhz != i_split.req.mhz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_res.mhz     <= n_mhz;
            r_res.khz     <= n_khz;
            r_res.changed <= n_changed;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

FILE: rtl/acs_code.sv
// Stages 5 and 6: validates the new frequency and forms the packed channel code.
`default_nettype none

module acs_code (
    input  wire               i_clk,
    input  wire acs_pkg::t_ld i_ld,
    input  acs_pkg::t_cfg     i_cfg,
    input  acs_pkg::t_res     i_res,
    output acs_pkg::t_out     o_out
);

    acs_pkg::t_res r_s5_res;
    logic [8:0]    r_s5_mp;
    logic [9:0]    r_s5_kp;
    logic [6:0]    r_s5_q10;
    logic [3:0]    r_s5_q100;
    acs_pkg::t_out r_s6;

    logic       w_over;
    logic [8:0] w_mp;
    logic [9:0] w_kp;
    logic [9:0] w_r10_full;
    logic [9:0] w_two_full;
    logic [3:0] w_r10;
    logic [6:0] w_two;
    logic       w_in_band;
    logic       w_slot25;
    logic       w_bad833;
    logic       w_slot833;
    logic       w_valid;
    logic [8:0] w_moff;
    logic [10:0] w_v10;
    logic [11:0] w_code;

    // carry of the kHz part into the MHz part
    assign w_over = (i_res.khz >= acs_pkg::KHZ_PER_MHZ);
    assign w_mp   = {1'b0, i_res.mhz} + {8'd0, w_over};
    assign w_kp   = w_over ? (i_res.khz - acs_pkg::KHZ_PER_MHZ) : i_res.khz;

    always_ff @(posedge i_clk) begin
        if (i_ld.s5) begin
            r_s5_res  <= i_res;
            r_s5_mp   <= w_mp;
            r_s5_kp   <= w_kp;
            r_s5_q10  <= acs_pkg::div10(w_kp);
            r_s5_q100 <= acs_pkg::div100(w_kp);
        end
    end

    always_comb begin
        w_r10_full = r_s5_kp - ({3'd0, r_s5_q10} * 10'd10);
        w_two_full = r_s5_kp - ({6'd0, r_s5_q100} * 10'd100);
        w_r10      = w_r10_full[3:0];
        w_two      = w_two_full[6:0];
        w_in_band  = (r_s5_mp >= {1'b0, acs_pkg::MHZ_MIN}) &&
                     (r_s5_mp <= {1'b0, acs_pkg::MHZ_MAX});
        w_slot25   = (w_two == 7'd0) || (w_two == 7'd25) ||
                     (w_two == 7'd50) || (w_two == 7'd75);
        w_bad833   = w_slot25 || (w_two == 7'd20) || (w_two == 7'd45) ||
                     (w_two == 7'd70) || (w_two == 7'd95);
        w_slot833  = ((w_r10 == 4'd0) || (w_r10 == 4'd5)) && !w_bad833;
        w_valid    = w_in_band && ((w_slot25 && i_cfg.r25_en) ||
                                   (w_slot833 && i_cfg.r833_en));
        w_moff     = r_s5_mp - {1'b0, acs_pkg::MHZ_MIN};
        w_v10      = {6'd0, w_moff[4:0]} * 11'd100 + {4'd0, r_s5_q10};
        w_code     = w_valid ? ({w_v10, (w_r10 == 4'd5)} + 12'd1) : 12'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.s6) begin
            r_s6.mhz         <= r_s5_res.mhz;
            r_s6.khz         <= r_s5_res.khz;
            r_s6.changed     <= r_s5_res.changed;
            r_s6.freq_valid  <= w_valid;
            r_s6.packed_code <= w_code;
        end
    end

    assign o_out = r_s6;

endmodule

`default_nettype wire

FILE: rtl/airband_channel_step_core.sv
// Top level of the VHF airband tuning-knob channel stepper.
// Use:
//   Slave stream: one request per knob event. tuser carries req_type
//   (0 step the MHz part, 1 step the kHz part); tdata carries step_up,
//   large_step, mhz_in and khz_in.
//   Master stream: one result per request, in request order: the new MHz
//   and kHz parts, changed, freq_valid and the 12-bit packed channel code
//   (zero when the frequency is off band or off an enabled raster).
//   Config port: write enable, index and one data bit; index 0 enables the
//   25 kHz raster, index 1 the 8.33 kHz raster. Both reset to enabled.
//   Write only while no request is in flight.
// Timing: six register stages (input, /25 split, remainder, step, carry
//   and /10 split, validate and code). A request accepted into the input
//   stage moves through the later stages in order to the master side. One
//   request per cycle is sustained while the master side keeps tready high.
// Reset clears all stage valids and restores the raster enables. When the
//   master side stalls, each stage holds its request and tready drops once
//   every stage is full; nothing is lost or repeated.
`default_nettype none

module airband_channel_step_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave request stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // [0] step_up, [1] large_step, [9:2] mhz_in,
                                     // [19:10] khz_in, [23:20] zero
    input  wire         i_s_tuser,   // [0] req_type
    // master result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [7:0] mhz_out, [17:8] khz_out, [18] changed,
                                     // [19] freq_valid, [31:20] packed_code
    // configuration write port
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire         i_cfg_wdata
);

    localparam int NSTG = 6;

    acs_pkg::t_cfg   r_cfg;
    logic [NSTG:1]   r_vld;
    acs_pkg::t_req   r_s1;

    logic [NSTG:1]   w_free;
    acs_pkg::t_ld    w_ld;
    acs_pkg::t_split w_split;
    acs_pkg::t_res   w_res;
    acs_pkg::t_out   w_out;

    // raster enables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.r25_en  <= 1'b1;
            r_cfg.r833_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                acs_pkg::CFG_IDX_R25:  r_cfg.r25_en  <= i_cfg_wdata;
                acs_pkg::CFG_IDX_R833: r_cfg.r833_en <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // a stage may load when empty or when the stage after it moves on
    always_comb begin
        w_free[NSTG] = !r_vld[NSTG] || i_m_tready;
        for (int i = NSTG - 1; i >= 1; i--) begin
            w_free[i] = !r_vld[i] || w_free[i + 1];
        end
    end

    assign w_ld.s2 = w_free[2];
    assign w_ld.s3 = w_free[3];
    assign w_ld.s4 = w_free[4];
    assign w_ld.s5 = w_free[5];
    assign w_ld.s6 = w_free[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_free[1]) r_vld[1] <= i_s_tvalid;
            for (int i = 2; i <= NSTG; i++) begin
                if (w_free[i]) r_vld[i] <= r_vld[i - 1];
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (w_free[1]) begin
            r_s1.req_type   <= i_s_tuser;
            r_s1.step_up    <= i_s_tdata[0];
            r_s1.large_step <= i_s_tdata[1];
            r_s1.mhz        <= i_s_tdata[9:2];
            r_s1.khz        <= i_s_tdata[19:10];
        end
    end

    acs_khz_split u_split (
        .i_clk   (i_clk),
        .i_ld    (w_ld),
        .i_req   (r_s1),
        .o_split (w_split)
    );

    acs_step u_step (
        .i_clk   (i_clk),
        .i_ld    (w_ld.s4),
        .i_cfg   (r_cfg),
        .i_split (w_split),
        .o_res   (w_res)
    );

    acs_code u_code (
        .i_clk (i_clk),
        .i_ld  (w_ld),
        .i_cfg (r_cfg),
        .i_res (w_res),
        .o_out (w_out)
    );

    assign o_s_tready = w_free[1];
    assign o_m_tvalid = r_vld[NSTG];
    assign o_m_tdata  = {w_out.packed_code, w_out.freq_valid, w_out.changed,
                         w_out.khz, w_out.mhz};

    // full pipeline with a stalled receiver takes no new request
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_vld == '1) && !i_m_tready) |-> !o_s_tready)
        else $error("request taken while pipeline full and stalled");

    // a valid result with kHz below one MHz lies in the band
    a_valid_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_out.freq_valid && (w_out.khz < acs_pkg::KHZ_PER_MHZ)) |->
        ((w_out.mhz >= acs_pkg::MHZ_MIN) && (w_out.mhz <= acs_pkg::MHZ_MAX)))
        else $error("valid frequency outside the band");

    // valid flag and channel code agree
    a_code_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_out.freq_valid == (w_out.packed_code != 12'd0)))
        else $error("packed code disagrees with valid flag");

    // nothing is presented straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result presented after reset");

endmodule

`default_nettype wire

FILE: tb/sv/acs_checker.sv
`timescale 1ns / 100ps
// Result checker for the airband channel stepper: predicts every request and compares.
module acs_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [23:0] i_s_tdata,   // [0] step_up, [1] large_step, [9:2] mhz_in,
                                     // [19:10] khz_in, [23:20] zero
    input  wire         i_s_tuser,   // [0] req_type
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [31:0] i_m_tdata,   // [7:0] mhz_out, [17:8] khz_out, [18] changed,
                                     // [19] freq_valid, [31:20] packed_code
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire         i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned GRID        = 25;
    localparam int unsigned DOWN_OFS    = 6;   // large 8.33-only step down
    localparam int unsigned BAND_BASE   = 118000;
    localparam int unsigned CODE_MASK   = 'h7FF;

    typedef struct {
        logic [7:0]  mhz;
        logic [9:0]  khz;
        logic        changed;
        logic        freq_valid;
        logic [11:0] code;
    } t_knob_result;

    t_knob_result awaited_results[$];
    logic         r25_on;
    logic         r833_on;
    int           mismatch_count = 0;

    // 8.33 kHz slot: last two digits a multiple of 5, not on or 5 kHz below a 25 kHz channel
    function automatic bit fine_slot(input int unsigned two);
        if (two % 5 != 0) return 1'b0;
        case (two)
            0, 20, 25, 45, 50, 70, 75, 95: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    // walk in 5 kHz steps to the nearest usable slot; two moves at most
    function automatic int unsigned nearest_slot(input int unsigned k, input bit up,
                                                 input bit both);
        for (int i = 0; i < 3; i++) begin
            if (fine_slot(k % 100) || (both && k % GRID == 0)) break;
            if (up) k += 5;
            else if (k >= 5) k -= 5;
        end
        return k;
    endfunction

    function automatic int unsigned stepped_khz(input int unsigned k, input bit up,
                                                input bit coarse);
        int unsigned t;
        if (r25_on && r833_on) begin
            if (!up) begin
                if (k <= 5) return 0;
                if (k > acs_pkg::KHZ_TOP_FINE) return acs_pkg::KHZ_TOP_FINE;
                if (coarse) return ((k - 1) / GRID) * GRID;
                return nearest_slot(((k - 1) / 5) * 5, 1'b0, 1'b1);
            end
            if (k >= acs_pkg::KHZ_UP_LIMIT)
                return coarse ? acs_pkg::KHZ_TOP_25 : acs_pkg::KHZ_TOP_FINE;
            if (coarse)
                return (k >= acs_pkg::KHZ_25_UP_LIMIT) ? acs_pkg::KHZ_TOP_25
                                                       : (k / GRID + 1) * GRID;
            return nearest_slot((k / 5 + 1) * 5, 1'b1, 1'b1);
        end
        if (r25_on) begin
            // coarse raster only, large_step has no effect
            if (!up) begin
                if (k <= GRID) return 0;
                if (k > acs_pkg::KHZ_TOP_25) return acs_pkg::KHZ_TOP_25;
                return ((k - 1) / GRID) * GRID;
            end
            return (k >= acs_pkg::KHZ_25_UP_LIMIT) ? acs_pkg::KHZ_TOP_25
                                                   : (k / GRID + 1) * GRID;
        end
        if (r833_on) begin
            if (!up) begin
                if (k <= 10) return 5;
                if (k > acs_pkg::KHZ_TOP_FINE) return acs_pkg::KHZ_TOP_FINE;
                if (coarse) return ((k - DOWN_OFS) / GRID) * GRID + 5;
                return nearest_slot(((k - 1) / 5) * 5, 1'b0, 1'b0);
            end
            if (k < 5) return 5;
            if (k >= acs_pkg::KHZ_UP_LIMIT) return acs_pkg::KHZ_TOP_FINE;
            if (coarse) begin
                t = (k / GRID + 1) * GRID + 5;
                return (t > acs_pkg::KHZ_TOP_FINE) ? acs_pkg::KHZ_TOP_FINE : t;
            end
            return nearest_slot((k / 5 + 1) * 5, 1'b1, 1'b0);
        end
        return k;   // no raster: kHz part frozen
    endfunction

    function automatic t_knob_result knob_outcome(input logic kind, input logic up,
                                                  input logic coarse, input logic [7:0] mhz,
                                                  input logic [9:0] khz);
        t_knob_result r;
        int unsigned  nm;
        int unsigned  nk;
        int unsigned  f;
        int unsigned  v;
        int unsigned  c;
        nm = mhz;
        nk = khz;
        if (kind == acs_pkg::REQ_MHZ) begin
            if (up && mhz < acs_pkg::MHZ_MAX) nm = mhz + 1;
            else if (!up && mhz > acs_pkg::MHZ_MIN) nm = mhz - 1;
            r.changed = (nm != mhz);
        end else begin
            nk = stepped_khz(khz, up, coarse);
            r.changed = (nk != khz);
        end
        f = nm * 1000 + nk;
        r.freq_valid = 1'b0;
        if (f / 1000 >= acs_pkg::MHZ_MIN && f / 1000 <= acs_pkg::MHZ_MAX)
            r.freq_valid = (f % GRID == 0 && r25_on) || (fine_slot(f % 100) && r833_on);
        r.code = '0;
        if (r.freq_valid) begin
            v = f - BAND_BASE;
            c = ((v / 10) & CODE_MASK) << 1;
            if (v % 10 == 5) c = c | 1;
            r.code = 12'(c + 1);
        end
        r.mhz = 8'(nm);
        r.khz = 10'(nk);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_knob_result want;
        if (!i_rst_n) begin
            r25_on  = 1'b1;
            r833_on = 1'b1;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == acs_pkg::CFG_IDX_R25) r25_on = i_cfg_wdata;
                else r833_on = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(knob_outcome(i_s_tuser, i_s_tdata[0], i_s_tdata[1],
                                                       i_s_tdata[9:2], i_s_tdata[19:10]));
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result, tdata %h", i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("mhz_out", want.mhz, i_m_tdata[7:0]);
                    check_field("khz_out", want.khz, i_m_tdata[17:8]);
                    check_field("changed", want.changed, i_m_tdata[18]);
                    check_field("freq_valid", want.freq_valid, i_m_tdata[19]);
                    check_field("packed_code", want.code, i_m_tdata[31:20]);
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= awaited_results.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top for the airband channel stepper: stimulus, back-pressure and verdict.
module tb;

    localparam int RANDOM_PER_PHASE = 320;
    localparam int CALM_TAIL        = 150;
    // raster enables per phase, bit n is phase n: both, 25 only, 8.33 only, none, both
    localparam logic [4:0] PHASE_R25  = 5'b10011;
    localparam logic [4:0] PHASE_R833 = 5'b10101;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic        cfg_idx;
    logic        cfg_wdata;
    int          fail_count;
    int          pending;
    bit          calm = 1'b0;   // no idling on either side near the end

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    airband_channel_step_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    acs_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // one knob request, with an occasional gap before it
    task automatic knob(input logic kind, input logic up, input logic coarse,
                        input logic [7:0] mhz, input logic [9:0] khz);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'd0, khz, mhz, coarse, up};
        do @(posedge clk); while (!s_tready);
    endtask

    // bias towards the band and the clamp regions, with some full-range noise
    task automatic random_knob();
        logic [7:0]  m;
        logic [9:0]  k;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        m = (pick == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(117, 137));
        pick = $urandom_range(0, 15);
        if (pick == 0) k = 10'($urandom_range(0, 1023));
        else if (pick < 4)
            k = $urandom_range(0, 1) ? 10'($urandom_range(0, 40)) : 10'($urandom_range(940, 1023));
        else if (pick < 12) k = 10'(5 * $urandom_range(0, 199));
        else k = 10'($urandom_range(0, 999));
        knob(($urandom_range(0, 3) != 0) ? acs_pkg::REQ_KHZ : acs_pkg::REQ_MHZ,
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), m, k);
    endtask

    // stop sending and wait for every outstanding request to come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_rasters(input logic en25, input logic en833);
        cfg_we    <= 1'b1;
        cfg_idx   <= acs_pkg::CFG_IDX_R25;
        cfg_wdata <= en25;
        @(posedge clk);
        cfg_idx   <= acs_pkg::CFG_IDX_R833;
        cfg_wdata <= en833;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: short stalls, long ready stretches, nothing once calm
    initial begin : backpressure
        int unsigned pick;
        m_tready <= 1'b1;
        forever begin
            @(posedge clk);
            pick = $urandom_range(0, 15);
            if (!calm && pick < 2) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                m_tready <= 1'b1;
            end else if (pick == 2) begin
                repeat ($urandom_range(30, 60)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= acs_pkg::REQ_MHZ;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= acs_pkg::CFG_IDX_R25;
        cfg_wdata <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            settle();
            set_rasters(PHASE_R25[ph], PHASE_R833[ph]);
            if (ph == 0) begin
                // MHz clamps, off-band and out-of-range kHz pass-through
                knob(acs_pkg::REQ_MHZ, 1'b1, 1'b0, 8'd136, 10'd0);
                knob(acs_pkg::REQ_MHZ, 1'b0, 1'b0, 8'd118, 10'd0);
                knob(acs_pkg::REQ_MHZ, 1'b1, 1'b0, 8'd0, 10'd1023);
                knob(acs_pkg::REQ_MHZ, 1'b0, 1'b1, 8'd255, 10'd999);
                knob(acs_pkg::REQ_MHZ, 1'b1, 1'b0, 8'd135, 10'd990);
                knob(acs_pkg::REQ_MHZ, 1'b0, 1'b0, 8'd119, 10'd5);
                // kHz down: floor, fine just above floor, ceiling clamp, large to 0
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd118, 10'd0);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd118, 10'd5);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd118, 10'd6);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd120, 10'd1023);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b1, 8'd120, 10'd25);
                // kHz up: top clamps, large cap, fine slot skipping; then fine down steps and off-band requests
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b0, 8'd121, 10'd985);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b1, 8'd121, 10'd985);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b1, 8'd122, 10'd950);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b1, 8'd122, 10'd949);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b0, 8'd123, 10'd15);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b0, 8'd123, 10'd90);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd124, 10'd30);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd124, 10'd50);
                knob(acs_pkg::REQ_KHZ, 1'b0, 1'b0, 8'd136, 10'd100);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b1, 8'd255, 10'd1023);
                knob(acs_pkg::REQ_KHZ, 1'b1, 1'b0, 8'd137, 10'd999);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                calm = (ph == 4) && (n >= RANDOM_PER_PHASE - CALM_TAIL);
                random_knob();
            end
        end

        settle();
        repeat (20) @(posedge clk);   // pipeline is six deep
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
